>>> design/ccrt_pkg.sv
// ----------------------------------------------------------------------------
// ccrt_pkg
// Types, codes and helpers shared by the CAN command retry table.
// ----------------------------------------------------------------------------
package ccrt_pkg;

  // operation codes
  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_RETRY = 2'd2;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  // register index of timeout_ticks
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam int          CNT_W         = 4;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 4'd8;
  localparam logic [3:0]  MAX_LEN       = 4'd8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] command_id;
    logic [10:0] expected_reply_id;
    logic [63:0] payload;
    logic [3:0]  payload_length;
    logic [31:0] current_time;
  } cmd_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] frame_id;
    logic [63:0] frame_payload;
    logic [3:0]  frame_length;
    logic        hit_flag;
    logic        last_result;
  } res_item_t;

  typedef struct packed {
    logic [10:0] command_id;
    logic [10:0] resp_id;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [31:0] sent_time;
  } slot_entry_t;

  // write request towards the slot memory
  typedef struct packed {
    logic        we_entry;
    logic        we_time;
    slot_entry_t data;
  } slot_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  function automatic logic [3:0] sat_len(input logic [3:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  // zero the bytes at and above len (len already saturated)
  function automatic logic [63:0] keep_bytes(input logic [63:0] data, input logic [3:0] len);
    logic [63:0] res;
    res = data;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= len) res[8*b +: 8] = 8'h00;
    end
    return res;
  endfunction

endpackage

>>> design/ccrt_slot_ram.sv
// ----------------------------------------------------------------------------
// ccrt_slot_ram
// Slot storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccrt_slot_ram #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                  clk,
  input  ccrt_pkg::slot_wr_t    wr,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [IDX_W-1:0]      raddr,
  output ccrt_pkg::slot_entry_t rdata
);
  import ccrt_pkg::*;

  logic [10:0] cmd_mem  [DEPTH];
  logic [10:0] rep_mem  [DEPTH];
  logic [63:0] data_mem [DEPTH];
  logic [3:0]  len_mem  [DEPTH];
  logic [31:0] time_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_entry) begin
      cmd_mem[waddr]  <= wr.data.command_id;
      rep_mem[waddr]  <= wr.data.resp_id;
      data_mem[waddr] <= wr.data.payload;
      len_mem[waddr]  <= wr.data.length;
    end
    if (wr.we_entry || wr.we_time) time_mem[waddr] <= wr.data.sent_time;
  end

  always_ff @(posedge clk) begin
    rdata.command_id <= cmd_mem[raddr];
    rdata.resp_id    <= rep_mem[raddr];
    rdata.payload    <= data_mem[raddr];
    rdata.length     <= len_mem[raddr];
    rdata.sent_time  <= time_mem[raddr];
  end

endmodule

>>> design/ccrt_ctrl.sv
// ----------------------------------------------------------------------------
// ccrt_ctrl
// Slot sequencer: walks the slots one at a time for send, reply and retry,
// holds the latest result until it is known whether it is the last one.
// ----------------------------------------------------------------------------
module ccrt_ctrl #(
  parameter int SLOT_COUNT = 8,
  parameter int IDX_W      = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  ccrt_pkg::cmd_item_t   cmd_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output ccrt_pkg::res_item_t   res_item,
  input  logic [31:0]           timeout_ticks,
  output ccrt_pkg::slot_wr_t    wr,
  output logic [IDX_W-1:0]      idx,
  input  ccrt_pkg::slot_entry_t rd
);
  import ccrt_pkg::*;

  state_t          state, state_next;
  cmd_item_t       cur;
  logic [SLOT_COUNT-1:0] active;
  res_item_t       held;
  res_item_t       flush_item;
  logic            held_valid;
  logic [CNT_W-1:0] count;

  logic        accept, op_known, last_slot, out_free, slot_act;
  logic        due, match, take, can_go, push;
  logic [31:0] age;
  logic [3:0]  in_len;

  assign in_len   = sat_len(cmd_item.payload_length);
  assign accept   = cmd_valid && !cmd_stall;
  assign op_known = (cmd_item.operation == OP_SEND) || (cmd_item.operation == OP_REPLY) ||
                    (cmd_item.operation == OP_RETRY);
  assign last_slot = (idx == IDX_W'(SLOT_COUNT - 1));
  assign out_free  = !res_valid || !res_stall;
  assign slot_act  = active[idx];

  // shared compare unit, one slot per visit
  assign age   = cur.current_time - rd.sent_time;
  assign due   = (age >= timeout_ticks);
  assign match = (rd.resp_id == cur.expected_reply_id);

  // action decode for the slot under inspection
  always_comb begin
    take   = 1'b0;
    can_go = 1'b1;
    unique case (cur.operation)
      OP_SEND:  take = !slot_act;
      OP_REPLY: take = slot_act && match;
      OP_RETRY: begin
        take   = slot_act && due && (count < MAX_RESULTS);
        // a second due entry must wait until the held one can move out
        can_go = !(take && held_valid && !out_free);
      end
      default:  take = 1'b0;
    endcase
  end

  // result register loads either an earlier retry frame or the final result
  assign push = ((state == ST_CHECK) && (cur.operation == OP_RETRY) && take && can_go &&
                 held_valid) || ((state == ST_FLUSH) && out_free);

  always_comb begin
    flush_item             = held;
    flush_item.last_result = 1'b1;
  end

  always_comb begin
    wr.we_entry        = (state == ST_CHECK) && (cur.operation == OP_SEND) && take;
    wr.we_time         = (state == ST_CHECK) && (cur.operation == OP_RETRY) && take && can_go;
    wr.data.command_id = cur.command_id;
    wr.data.resp_id    = cur.expected_reply_id;
    wr.data.payload    = cur.payload;
    wr.data.length     = cur.payload_length;
    wr.data.sent_time  = cur.current_time;
    cmd_stall          = rst || (state != ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && op_known) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_CHECK;
      ST_CHECK: begin
        if (cur.operation == OP_RETRY) begin
          if (can_go) begin
            if (!last_slot) state_next = ST_FETCH;
            else if (held_valid || take) state_next = ST_FLUSH;
            else state_next = ST_IDLE;
          end
        end else if (take || last_slot) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FLUSH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      held_valid <= 1'b0;
      res_valid  <= 1'b0;
      count      <= '0;
      idx        <= '0;
    end else begin
      state <= state_next;
      if (push) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;

      if (accept) begin
        cur.operation         <= cmd_item.operation;
        cur.command_id        <= cmd_item.command_id;
        cur.expected_reply_id <= cmd_item.expected_reply_id;
        cur.payload           <= keep_bytes(cmd_item.payload, in_len);
        cur.payload_length    <= in_len;
        cur.current_time      <= cmd_item.current_time;
        idx        <= '0;
        count      <= '0;
        held_valid <= 1'b0;
      end

      if (state == ST_CHECK) begin
        if (cur.operation == OP_SEND && (take || last_slot)) begin
          if (take) active[idx] <= 1'b1;
          held.result_kind   <= KIND_FRAME;
          held.frame_id      <= cur.command_id;
          held.frame_payload <= cur.payload;
          held.frame_length  <= cur.payload_length;
          held.hit_flag      <= take;
          held.last_result   <= 1'b0;
          held_valid         <= 1'b1;
        end else if (cur.operation == OP_REPLY && (take || last_slot)) begin
          if (take) active[idx] <= 1'b0;
          held.result_kind   <= KIND_ACK;
          held.frame_id      <= '0;
          held.frame_payload <= '0;
          held.frame_length  <= '0;
          held.hit_flag      <= take;
          held.last_result   <= 1'b0;
          held_valid         <= 1'b1;
        end else if (cur.operation == OP_RETRY && take && can_go) begin
          if (held_valid) res_item <= held;
          held.result_kind   <= KIND_FRAME;
          held.frame_id      <= rd.command_id;
          held.frame_payload <= rd.payload;
          held.frame_length  <= rd.length;
          held.hit_flag      <= 1'b0;
          held.last_result   <= 1'b0;
          held_valid         <= 1'b1;
          count              <= count + 1'b1;
        end
        if (state_next == ST_FETCH) idx <= idx + 1'b1;
      end

      if (state == ST_FLUSH && out_free) begin
        res_item   <= flush_item;
        held_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/can_command_retry_table.sv
// ----------------------------------------------------------------------------
// can_command_retry_table
// Pending-command table for standard-ID CAN commands with timed retransmit.
// ----------------------------------------------------------------------------
// One transaction at a time: the slots are visited in order, each in a fetch
// state (memory read) and then a check state (one compare in the shared unit).
// A send stops at the first free slot; a reply stops at the first match; a
// retry scan always visits every slot and can be held while the result side
// stalls. An unknown operation is dropped without leaving the idle state.
// timeout_ticks lies at byte address 0 of the register port and resets to 1000.
module can_command_retry_table #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ccrt_pkg::cmd_item_t cmd_item,
  output logic                res_valid,
  input  logic                res_stall,
  output ccrt_pkg::res_item_t res_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ccrt_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [31:0]      timeout_ticks;
  slot_wr_t         wr;
  slot_entry_t      rd;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_ticks : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
      timeout_ticks <= pwdata;
    end
  end

  ccrt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd_item     (cmd_item),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_item     (res_item),
    .timeout_ticks(timeout_ticks),
    .wr           (wr),
    .idx          (idx),
    .rd           (rd)
  );

  ccrt_slot_ram #(
    .DEPTH(SLOT_COUNT),
    .IDX_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .wr   (wr),
    .waddr(idx),
    .raddr(idx),
    .rdata(rd)
  );

`ifndef ASSERT_OFF
  // an unknown operation is dropped without occupying the sequencer
  a_unknown_op_dropped: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && !(cmd_item.operation == OP_SEND ||
    cmd_item.operation == OP_REPLY || cmd_item.operation == OP_RETRY) |=> !cmd_stall)
    else $error("unknown operation held the sequencer");

  // a send always occupies the sequencer for its slot walk
  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd_item.operation == OP_SEND |=> cmd_stall)
    else $error("send transaction did not start a slot walk");

  // a reply acknowledgement is the last result of its transaction and carries an empty frame
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.result_kind == KIND_ACK |-> res_item.last_result &&
    res_item.frame_id == 11'd0 && res_item.frame_length == 4'd0)
    else $error("reply acknowledgement malformed");
`endif

endmodule
